FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define KAV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define KAV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/kav_pkg.sv
// ----------------------------------------------------------------------------
// kav_pkg
// Types, constants and helpers of the altitude/velocity Kalman filter.
// ----------------------------------------------------------------------------
package kav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int MUL_IN_W  = 33;
  localparam int MUL_W     = 2 * MUL_IN_W;
  localparam int SUM_W     = MUL_W + 2;
  localparam int CFG_W     = 31;
  localparam int IDX_W     = 3;
  localparam int DT_W      = 17;

  localparam logic [DT_W-1:0]  RST_TIME_STEP = DT_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [CFG_W-1:0] RST_QPOS      = CFG_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [CFG_W-1:0] RST_QVEL      = CFG_W'(64'd1 << FRAC_BITS);
  localparam logic [CFG_W-1:0] RST_MEAS      = CFG_W'(64'd2 << FRAC_BITS);
  localparam logic [DATA_W-1:0] ONE_Q        = DATA_W'(64'd1 << FRAC_BITS);

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_TIME_STEP = 3'd0;
  localparam logic [IDX_W-1:0] REG_QPOS      = 3'd1;
  localparam logic [IDX_W-1:0] REG_QVEL      = 3'd2;
  localparam logic [IDX_W-1:0] REG_MEAS      = 3'd3;

  // datapath steps: one multiply, then one write-back each
  typedef enum logic [3:0] {
    S_DT2, S_VDT, S_ADT2, S_ADT, S_CDT, S_VVDT2, S_VVDT,
    S_K0Y, S_K1Y, S_K0PPP, S_K0PVP, S_K1PPP, S_K1PVP
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_WB, ST_DIV_START, ST_DIV_WAIT, ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic  load;
    logic  reinit;
    logic  mul;
    logic  wb;
    logic  div_start;
    logic  out_load;
    step_t step;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = $signed({{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
    lo = $signed({{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});
    if (v > hi) begin
      return hi[DATA_W-1:0];
    end else if (v < lo) begin
      return lo[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

FILE: design/kav_if.sv
// ----------------------------------------------------------------------------
// kav_if
// Valid/ready channels: measurement requests in, estimates out.
// ----------------------------------------------------------------------------
interface kav_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] meas_altitude;
  logic signed [31:0] accel_in;
  modport source (output valid, op, meas_altitude, accel_in, input ready);
  modport sink   (input valid, op, meas_altitude, accel_in, output ready);
endinterface

interface kav_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] est_altitude;
  logic signed [31:0] est_velocity;
  modport source (output valid, est_altitude, est_velocity, input ready);
  modport sink   (input valid, est_altitude, est_velocity, output ready);
endinterface

FILE: design/kav_div.sv
// ----------------------------------------------------------------------------
// kav_div
// Two-lane radix-2 restoring divider sharing one divisor: (num << F) / den,
// truncated toward zero and saturated. Zero divisor gives zero.
// ----------------------------------------------------------------------------
module kav_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [31:0]        num0,
  input  logic signed [31:0]        num1,
  input  logic signed [32:0]        den,
  output logic                      done,
  output logic signed [31:0]        q0,
  output logic signed [31:0]        q1
);
  localparam int NUMW  = 32 + kav_pkg::FRAC_BITS;
  localparam int DENW  = 33;
  localparam int REMW  = DENW + 1;
  localparam int CNT_W = $clog2(NUMW + 1);

  logic [NUMW-1:0]  quo [2];
  logic [REMW-1:0]  rem [2];
  logic [REMW-1:0]  rsh [2];
  logic             ge  [2];
  logic             neg [2];
  logic [DENW-1:0]  dmag;
  logic             dzero;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [32:0]      n0x;
  logic [32:0]      n1x;
  logic [33:0]      dx;
  logic signed [NUMW:0] qs [2];

  always_comb begin
    n0x = {num0[31], num0};
    n1x = {num1[31], num1};
    dx  = {den[32], den};
    if (n0x[32]) n0x = -n0x;
    if (n1x[32]) n1x = -n1x;
    if (dx[33]) dx = -dx;
    for (int i = 0; i < 2; i++) begin
      rsh[i] = {rem[i][REMW-2:0], quo[i][NUMW-1]};
      ge[i]  = rsh[i] >= {1'b0, dmag};
      qs[i]  = neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
    end
    q0 = dzero ? '0 : kav_pkg::sat32(kav_pkg::SUM_W'(qs[0]));
    q1 = dzero ? '0 : kav_pkg::sat32(kav_pkg::SUM_W'(qs[1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= CNT_W'(NUMW);
        quo[0] <= {n0x[31:0], {kav_pkg::FRAC_BITS{1'b0}}};
        quo[1] <= {n1x[31:0], {kav_pkg::FRAC_BITS{1'b0}}};
        rem[0] <= '0;
        rem[1] <= '0;
        neg[0] <= num0[31] ^ den[32];
        neg[1] <= num1[31] ^ den[32];
        dmag   <= dx[DENW-1:0];
        dzero  <= (den == '0);
      end else if (busy) begin
        for (int i = 0; i < 2; i++) begin
          rem[i] <= ge[i] ? rsh[i] - {1'b0, dmag} : rsh[i];
          quo[i] <= {quo[i][NUMW-2:0], ge[i]};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: design/kav_datapath.sv
// ----------------------------------------------------------------------------
// kav_datapath
// Filter state, configuration registers, one shared multiplier with a
// registered product, write-back adders with saturation, and the divider.
// ----------------------------------------------------------------------------
module kav_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  kav_pkg::dp_cmd_t            cmd,
  output kav_pkg::dp_status_t         status,
  input  logic                        cfg_write,
  input  logic [kav_pkg::IDX_W-1:0]   cfg_index,
  input  logic [kav_pkg::CFG_W-1:0]   cfg_data,
  input  logic signed [31:0]          meas_altitude,
  input  logic signed [31:0]          accel_in,
  output logic signed [31:0]          est_altitude,
  output logic signed [31:0]          est_velocity
);
  localparam int F  = kav_pkg::FRAC_BITS;
  localparam int SW = kav_pkg::SUM_W;

  logic [kav_pkg::DT_W-1:0]  time_step;
  logic [kav_pkg::CFG_W-1:0] qpos, qvel, rmeas;

  logic signed [31:0] alt, vel, pp, pv, cvp, vv;
  logic signed [31:0] z, a, dt2, xp, vpr, ppp, pvp, vpp, vvp, y;
  logic signed [32:0] s;
  logic signed [31:0] k0, k1;
  logic signed [SW-1:0] acc;
  logic signed [kav_pkg::MUL_W-1:0] prod;
  logic signed [kav_pkg::MUL_IN_W-1:0] opa, opb, dts;
  logic signed [SW-1:0] psh, psh1;
  logic div_done;

  assign dts  = $signed({{(kav_pkg::MUL_IN_W-kav_pkg::DT_W){1'b0}}, time_step});
  assign psh  = SW'(prod >>> F);
  assign psh1 = SW'(prod >>> (F + 1));
  assign status.div_done = div_done;

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd.step)
      kav_pkg::S_DT2:   begin opa = dts;          opb = dts;        end
      kav_pkg::S_VDT:   begin opa = 33'(vel);     opb = dts;        end
      kav_pkg::S_ADT2:  begin opa = 33'(a);       opb = 33'(dt2);   end
      kav_pkg::S_ADT:   begin opa = 33'(a);       opb = dts;        end
      kav_pkg::S_CDT:   begin opa = 33'(pv) + 33'(cvp); opb = dts;  end
      kav_pkg::S_VVDT2: begin opa = 33'(vv);      opb = 33'(dt2);   end
      kav_pkg::S_VVDT:  begin opa = 33'(vv);      opb = dts;        end
      kav_pkg::S_K0Y:   begin opa = 33'(k0);      opb = 33'(y);     end
      kav_pkg::S_K1Y:   begin opa = 33'(k1);      opb = 33'(y);     end
      kav_pkg::S_K0PPP: begin opa = 33'(k0);      opb = 33'(ppp);   end
      kav_pkg::S_K0PVP: begin opa = 33'(k0);      opb = 33'(pvp);   end
      kav_pkg::S_K1PPP: begin opa = 33'(k1);      opb = 33'(ppp);   end
      kav_pkg::S_K1PVP: begin opa = 33'(k1);      opb = 33'(pvp);   end
      default:          begin opa = '0;           opb = '0;         end
    endcase
  end

  kav_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num0  (ppp),
    .num1  (vpp),
    .den   (s),
    .done  (div_done),
    .q0    (k0),
    .q1    (k1)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= kav_pkg::RST_TIME_STEP;
      qpos      <= kav_pkg::RST_QPOS;
      qvel      <= kav_pkg::RST_QVEL;
      rmeas     <= kav_pkg::RST_MEAS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        kav_pkg::REG_TIME_STEP: time_step <= cfg_data[kav_pkg::DT_W-1:0];
        kav_pkg::REG_QPOS:      qpos      <= cfg_data;
        kav_pkg::REG_QVEL:      qvel      <= cfg_data;
        kav_pkg::REG_MEAS:      rmeas     <= cfg_data;
        default: ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      alt <= '0;
      vel <= '0;
      pp  <= kav_pkg::ONE_Q;
      pv  <= '0;
      cvp <= '0;
      vv  <= kav_pkg::ONE_Q;
    end else if (cmd.wb) begin
      case (cmd.step)
        kav_pkg::S_K0Y:   alt <= kav_pkg::sat32(SW'(xp) + psh);
        kav_pkg::S_K1Y:   vel <= kav_pkg::sat32(SW'(vpr) + psh);
        kav_pkg::S_K0PPP: pp  <= kav_pkg::sat32(SW'(ppp) - psh);
        kav_pkg::S_K0PVP: pv  <= kav_pkg::sat32(SW'(pvp) - psh);
        kav_pkg::S_K1PPP: cvp <= kav_pkg::sat32(SW'(vpp) - psh);
        kav_pkg::S_K1PVP: vv  <= kav_pkg::sat32(SW'(vvp) - psh);
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z <= meas_altitude;
      a <= accel_in;
    end
    if (cmd.mul) begin
      prod <= opa * opb;
    end
    if (cmd.wb) begin
      case (cmd.step)
        kav_pkg::S_DT2:   dt2 <= kav_pkg::sat32(psh);
        kav_pkg::S_VDT:   acc <= SW'(alt) + psh;
        kav_pkg::S_ADT2:  xp  <= kav_pkg::sat32(acc + psh1);
        kav_pkg::S_ADT:   vpr <= kav_pkg::sat32(SW'(vel) + psh);
        kav_pkg::S_CDT:   acc <= SW'(pp) + psh + SW'($signed({1'b0, qpos}));
        kav_pkg::S_VVDT2: begin
          ppp <= kav_pkg::sat32(acc + psh);
          vvp <= kav_pkg::sat32(SW'(vv) + SW'($signed({1'b0, qvel})));
        end
        kav_pkg::S_VVDT: begin
          pvp <= kav_pkg::sat32(SW'(pv) + psh);
          vpp <= kav_pkg::sat32(SW'(cvp) + psh);
          y   <= kav_pkg::sat32(SW'(z) - SW'(xp));
          s   <= 33'(ppp) + $signed({2'b00, rmeas});
        end
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      est_altitude <= alt;
      est_velocity <= vel;
    end
  end
endmodule

FILE: design/kav_ctrl.sv
// ----------------------------------------------------------------------------
// kav_ctrl
// Sequencer: walks the multiply/write-back steps, runs the divider, and
// owns both handshakes.
// ----------------------------------------------------------------------------
module kav_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_op,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kav_pkg::dp_cmd_t      cmd,
  input  kav_pkg::dp_status_t   status
);
  kav_pkg::ctl_state_t state, state_next;
  kav_pkg::step_t      step, step_next;
  logic                out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kav_pkg::ST_IDLE;
      step      <= kav_pkg::S_DT2;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.step       = step;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      kav_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op) begin
            cmd.reinit = 1'b1;
          end else begin
            cmd.load = 1'b1;
          end
          step_next  = kav_pkg::S_DT2;
          state_next = in_op ? kav_pkg::ST_FINISH : kav_pkg::ST_MUL;
        end
      end
      kav_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = kav_pkg::ST_WB;
      end
      kav_pkg::ST_WB: begin
        cmd.wb = 1'b1;
        if (step == kav_pkg::S_VVDT) begin
          state_next = kav_pkg::ST_DIV_START;
        end else if (step == kav_pkg::S_K1PVP) begin
          state_next = kav_pkg::ST_FINISH;
        end else begin
          step_next  = kav_pkg::step_t'(step + 1'b1);
          state_next = kav_pkg::ST_MUL;
        end
      end
      kav_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = kav_pkg::ST_DIV_WAIT;
      end
      kav_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          step_next  = kav_pkg::S_K0Y;
          state_next = kav_pkg::ST_MUL;
        end
      end
      kav_pkg::ST_FINISH: begin
        // wait for a free output slot
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = kav_pkg::ST_IDLE;
        end
      end
      default: state_next = kav_pkg::ST_IDLE;
    endcase
  end
endmodule

FILE: design/kalman_altitude_velocity.sv
// ----------------------------------------------------------------------------
// kalman_altitude_velocity
// Two-state (altitude, velocity) Kalman filter in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   sample: valid/ready request with op (0 update, 1 reinitialize),
//     meas_altitude and accel_in. result: valid/ready with est_altitude and
//     est_velocity, one per request.
//   cfg_write/cfg_index/cfg_data write time_step, process_noise_pos,
//     process_noise_vel and meas_noise (indexes 0..3); write only while idle.
//   Sequence: an update request runs seven multiply/write-back steps on the
//     shared multiplier, the 48-step restoring divider, six more steps for
//     the correction, and then loads the output register. A reinitialize
//     request resets the state and goes straight to loading the output
//     register.
//   One request is processed at a time; sample.ready is high while idle,
//     including while an earlier result waits in the output register.
//   If result is stalled, a finished request waits for the output register
//     to free up before the next request is taken.
//   Reset (rst, synchronous) restores the registers' defaults, zero estimate
//     and unit covariance, and drops any pending result.
// ----------------------------------------------------------------------------
module kalman_altitude_velocity (
  input  logic                       clk,
  input  logic                       rst,
  kav_in_if.sink                     sample,
  kav_out_if.source                  result,
  input  logic                       cfg_write,
  input  logic [kav_pkg::IDX_W-1:0]  cfg_index,
  input  logic [kav_pkg::CFG_W-1:0]  cfg_data
);
  kav_pkg::dp_cmd_t    cmd;
  kav_pkg::dp_status_t status;

  kav_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_op     (sample.op),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  kav_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .meas_altitude (sample.meas_altitude),
    .accel_in      (sample.accel_in),
    .est_altitude  (result.est_altitude),
    .est_velocity  (result.est_velocity)
  );
endmodule

FILE: design/kav_checker.sv
// ----------------------------------------------------------------------------
// kav_checker
// Port-level checks of the Kalman filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kav_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_op,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] est_altitude,
  input logic signed [31:0] est_velocity
);
  `KAV_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "result valid after reset")
  `KAV_ASSERT(a_out_holds, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `KAV_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "request taken while busy")
  `KAV_ASSERT(a_reinit_result, in_valid && in_ready && in_op && !out_valid |=> ##1 (out_valid && est_altitude == 0 && est_velocity == 0), "reinitialize result wrong")
endmodule

bind kalman_altitude_velocity kav_checker u_kav_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample.valid),
  .in_ready     (sample.ready),
  .in_op        (sample.op),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .est_altitude (result.est_altitude),
  .est_velocity (result.est_velocity)
);
